[rtl/core/audio_frame_mean_rms_normalizer_assert.svh]
// assertion macros for the frame normalizer
`ifndef AUDIO_FRAME_MEAN_RMS_NORMALIZER_ASSERT_SVH
`define AUDIO_FRAME_MEAN_RMS_NORMALIZER_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define AFMRN_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("afmrn assertion failed");

// next-cycle implication, sampled on i_clk, off during reset
`define AFMRN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("afmrn assertion failed");

`endif

[rtl/core/afmrn_pkg.sv]
// shared types and constants of the frame normalizer
package afmrn_pkg;

    localparam int SMP_W   = 16;
    localparam int LEN_W   = 7;
    localparam int EPS_W   = 32;
    localparam int FN_W    = 16;
    localparam int D_W     = 24;
    localparam int MW      = 62;
    localparam int ROOT_W  = 31;
    localparam int NUM_W   = 48;
    localparam int QUO_W   = 18;
    localparam int FRAC_SH = 12;
    localparam int CIDX_W  = 2;

    localparam logic [CIDX_W-1:0] CFG_FRAME_LEN = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_HOP_LEN   = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_EPSILON   = 2'd2;

    localparam logic [LEN_W-1:0] HOP_MAX       = 7'd64;
    localparam logic [LEN_W-1:0] FRAME_RST     = 7'd64;
    localparam logic [LEN_W-1:0] HOP_RST       = 7'd32;
    localparam logic [EPS_W-1:0] EPS_RST       = 32'd1;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

[rtl/core/afmrn_div.sv]
// iterative restoring divider, one quotient bit per cycle
module afmrn_div import afmrn_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_ctl          i_ctl,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [ROOT_W-1:0] i_den,
    output t_div_sts          o_sts,
    output logic [QUO_W-1:0]  o_quo
);

    localparam int CNT_W = $clog2(QUO_W);

    logic [ROOT_W:0]      r_rem;
    logic [QUO_W-1:0]     r_lo;
    logic [QUO_W-1:0]     r_quo;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [ROOT_W:0]      rem_sh;
    logic                 fits;

    always_comb begin
        rem_sh = {r_rem[ROOT_W-1:0], r_lo[QUO_W-1]};
        fits   = rem_sh >= {1'b0, i_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            // quotient is known to fit QUO_W bits, so the high part is below the divisor
            r_rem  <= (ROOT_W+1)'(i_num[NUM_W-1:QUO_W]);
            r_lo   <= i_num[QUO_W-1:0];
            r_quo  <= '0;
            r_cnt  <= '0;
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_rem <= fits ? rem_sh - {1'b0, i_den} : rem_sh;
            r_lo  <= {r_lo[QUO_W-2:0], 1'b0};
            r_quo <= {r_quo[QUO_W-2:0], fits};
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(QUO_W-1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quo      = r_quo;

endmodule

[rtl/core/audio_frame_mean_rms_normalizer.sv]
// Frame normalizer: takes one Q1.15 sample per transaction into a ring of MAX_FRAME entries.
// When a frame of frame_length samples is complete (and then every hop_length samples) it
// removes the frame mean, divides by sqrt(mean square + epsilon) and sends the frame, oldest
// first, as saturated Q4.12 values with the frame number and a last-of-frame mark. A sample
// that completes no frame does not stall the input. A completing sample holds the input
// stalled until the last value of the frame is registered for output, output stalls
// included: a sum pass (read, add) and a square pass (read, center, accumulate) over the
// ring, a short multiply chain, up to 28 normalize steps, a 31-step square root, then per
// value mostly the shared 18-step divider. row_end clears the counters after its own sample.
`include "audio_frame_mean_rms_normalizer_assert.svh"

module audio_frame_mean_rms_normalizer import afmrn_pkg::*; #(
    parameter int MAX_FRAME = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CIDX_W-1:0]       i_cfg_idx,
    input  logic [EPS_W-1:0]        i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [SMP_W-1:0] i_sample,
    input  logic                    i_row_end,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [SMP_W-1:0] o_norm_value,
    output logic [FN_W-1:0]         o_frame_number,
    output logic                    o_last_of_frame
);

    localparam int AW = $clog2(MAX_FRAME);
    localparam int FW = $clog2(MAX_FRAME + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_SUM_RD, S_SUM, S_SQ_RD, S_SQ_D, S_SQ_ACC,
        S_E1, S_E2, S_E3, S_E4, S_E5, S_NORM, S_SQRT,
        S_OUT_RD, S_OUT_D, S_OUT_A, S_OUT_SH, S_DIV, S_DIV_WAIT, S_EMIT
    } t_state;

    t_state r_state;

    logic [LEN_W-1:0] r_cfg_len;
    logic [LEN_W-1:0] r_cfg_hop;
    logic [EPS_W-1:0] r_cfg_eps;

    logic [SMP_W-1:0] r_ring [MAX_FRAME];
    logic [SMP_W-1:0] r_rd_data;
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_addr;
    logic [AW-1:0]    r_start;
    logic [FW-1:0]    r_fill;
    logic [LEN_W-1:0] r_hop_cd;
    logic [FN_W-1:0]  r_frame_cnt;
    logic [FN_W-1:0]  r_fn;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] r_cnt;

    logic signed [D_W-1:0] r_sum;
    logic signed [D_W-1:0] r_d;
    logic [MW-1:0]         r_q;
    logic [MW-1:0]         r_m;
    logic [MW-1:0]         r_x;
    logic [4:0]            r_k;
    logic [ROOT_W-1:0]     r_res;
    logic [ROOT_W+1:0]     r_rem;
    logic [NUM_W-1:0]      r_num;

    logic                    r_o_valid;
    logic signed [SMP_W-1:0] r_o_norm;
    logic [FN_W-1:0]         r_o_fn;
    logic                    r_o_last;

    logic                  acc;
    logic [LEN_W-1:0]      len_c;
    logic [LEN_W-1:0]      hop_c;
    logic [EPS_W-1:0]      eps_c;
    logic [AW-1:0]         wp_inc;
    logic [AW-1:0]         addr_inc;
    logic [LEN_W:0]        start_w;
    logic [FW-1:0]         fill_n;
    logic [LEN_W-1:0]      hop_n;
    logic                  emit;
    logic signed [D_W-1:0] s_ext;
    logic signed [D_W-1:0] l_ext;
    logic signed [D_W-1:0] prod;
    logic signed [D_W-1:0] d_val;
    logic signed [D_W-1:0] d_neg;
    logic [D_W-2:0]        d_abs;
    logic [2*D_W-3:0]      sq;
    logic [ROOT_W+1:0]     rem_sh;
    logic [ROOT_W+1:0]     trial;
    logic [NUM_W-1:0]      num_sh;
    logic signed [SMP_W-1:0] sat_val;
    logic                  last_el;

    t_div_ctl          div_ctl;
    t_div_sts          div_sts;
    logic [QUO_W-1:0]  div_quo;

    assign acc     = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        if (r_cfg_len < LEN_W'(2))                len_c = LEN_W'(2);
        else if (r_cfg_len > LEN_W'(MAX_FRAME))   len_c = LEN_W'(MAX_FRAME);
        else                                      len_c = r_cfg_len;
        if (r_cfg_hop == '0)                      hop_c = LEN_W'(1);
        else if (r_cfg_hop > HOP_MAX)             hop_c = HOP_MAX;
        else                                      hop_c = r_cfg_hop;
        eps_c = (r_cfg_eps == '0) ? EPS_W'(1) : r_cfg_eps;

        wp_inc   = (r_wp == AW'(MAX_FRAME - 1)) ? '0 : r_wp + 1'b1;
        addr_inc = (r_addr == AW'(MAX_FRAME - 1)) ? '0 : r_addr + 1'b1;
        if ((LEN_W+1)'(wp_inc) >= (LEN_W+1)'(len_c))
            start_w = (LEN_W+1)'(wp_inc) - (LEN_W+1)'(len_c);
        else
            start_w = (LEN_W+1)'(wp_inc) + (LEN_W+1)'(MAX_FRAME) - (LEN_W+1)'(len_c);

        fill_n = (r_fill < FW'(MAX_FRAME)) ? r_fill + 1'b1 : r_fill;
        hop_n  = (r_hop_cd != '0) ? r_hop_cd - 1'b1 : r_hop_cd;
        emit   = ((LEN_W+1)'(fill_n) >= (LEN_W+1)'(len_c)) && (hop_n == '0);

        // centered value scaled by L: d = L*s - sum
        s_ext = {{(D_W-SMP_W){r_rd_data[SMP_W-1]}}, r_rd_data};
        l_ext = {{(D_W-LEN_W){1'b0}}, r_len};
        prod  = s_ext * l_ext;
        d_val = prod - r_sum;
        d_neg = -r_d;
        d_abs = r_d[D_W-1] ? d_neg[D_W-2:0] : r_d[D_W-2:0];
        sq    = d_abs * d_abs;

        // one digit of the square root
        rem_sh = {r_rem[ROOT_W-1:0], r_x[MW-1:MW-2]};
        trial  = {r_res, 2'b01};

        num_sh = ((r_num << r_k) << FRAC_SH) + NUM_W'(r_res >> 1);

        if (r_d[D_W-1])
            sat_val = (div_quo > QUO_W'(32768)) ? -16'sd32768 : -$signed(div_quo[SMP_W-1:0]);
        else
            sat_val = (div_quo > QUO_W'(32767)) ? 16'sd32767 : $signed(div_quo[SMP_W-1:0]);

        last_el = (r_cnt == r_len - 1'b1);
    end

    // sample ring
    always_ff @(posedge i_clk) begin
        if (acc) r_ring[r_wp] <= i_sample;
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_ring[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len <= FRAME_RST;
            r_cfg_hop <= HOP_RST;
            r_cfg_eps <= EPS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_LEN: r_cfg_len <= i_cfg_data[LEN_W-1:0];
                CFG_HOP_LEN:   r_cfg_hop <= i_cfg_data[LEN_W-1:0];
                CFG_EPSILON:   r_cfg_eps <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign div_ctl.start = (r_state == S_DIV);

    afmrn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_num   (r_num),
        .i_den   (r_res),
        .o_sts   (div_sts),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_fill      <= '0;
            r_hop_cd    <= '0;
            r_frame_cnt <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            if (r_o_valid && !i_stall && r_state != S_EMIT) r_o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_wp <= wp_inc;
                        if (i_row_end) begin
                            r_fill      <= '0;
                            r_hop_cd    <= '0;
                            r_frame_cnt <= '0;
                        end else begin
                            r_fill   <= fill_n;
                            r_hop_cd <= emit ? hop_c : hop_n;
                            if (emit) r_frame_cnt <= r_frame_cnt + 1'b1;
                        end
                        if (emit) begin
                            r_fn        <= r_frame_cnt;
                            r_len       <= len_c;
                            r_start     <= start_w[AW-1:0];
                            r_addr      <= start_w[AW-1:0];
                            r_cnt       <= '0;
                            r_sum       <= '0;
                            r_q         <= '0;
                            r_state     <= S_SUM_RD;
                        end
                    end
                end
                S_SUM_RD: r_state <= S_SUM;
                S_SUM: begin
                    r_sum <= r_sum + s_ext;
                    if (last_el) begin
                        r_addr  <= r_start;
                        r_cnt   <= '0;
                        r_state <= S_SQ_RD;
                    end else begin
                        r_addr  <= addr_inc;
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_SUM_RD;
                    end
                end
                S_SQ_RD: r_state <= S_SQ_D;
                S_SQ_D: begin
                    r_d     <= d_val;
                    r_state <= S_SQ_ACC;
                end
                S_SQ_ACC: begin
                    r_q    <= r_q + MW'(sq);
                    r_addr <= addr_inc;
                    r_cnt  <= r_cnt + 1'b1;
                    r_state <= last_el ? S_E1 : S_SQ_RD;
                end
                S_E1: begin
                    r_m     <= MW'(eps_c) * MW'(r_len);
                    r_state <= S_E2;
                end
                S_E2: begin
                    r_m     <= r_m * MW'(r_len);
                    r_state <= S_E3;
                end
                S_E3: begin
                    r_m     <= r_m * MW'(r_len);
                    r_state <= S_E4;
                end
                S_E4: begin
                    r_m     <= r_m + r_q;
                    r_state <= S_E5;
                end
                S_E5: begin
                    r_x     <= r_m * MW'(r_len);
                    r_k     <= '0;
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    // bring the mean-square product up to at least 2^60
                    if (r_x[MW-1:MW-2] == 2'b00) begin
                        r_x <= r_x << 2;
                        r_k <= r_k + 1'b1;
                    end else begin
                        r_res   <= '0;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_x <= r_x << 2;
                    if (rem_sh >= trial) begin
                        r_rem <= rem_sh - trial;
                        r_res <= {r_res[ROOT_W-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_res <= {r_res[ROOT_W-2:0], 1'b0};
                    end
                    if (r_cnt == LEN_W'(ROOT_W - 1)) begin
                        r_cnt   <= '0;
                        r_addr  <= r_start;
                        r_state <= S_OUT_RD;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_OUT_RD: r_state <= S_OUT_D;
                S_OUT_D: begin
                    r_d     <= d_val;
                    r_state <= S_OUT_A;
                end
                S_OUT_A: begin
                    r_num   <= NUM_W'(d_abs) * NUM_W'(r_len);
                    r_state <= S_OUT_SH;
                end
                S_OUT_SH: begin
                    r_num   <= num_sh;
                    r_state <= S_DIV;
                end
                S_DIV: r_state <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (div_sts.done) r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_o_valid || !i_stall) begin
                        r_o_valid <= 1'b1;
                        r_o_norm  <= sat_val;
                        r_o_fn    <= r_fn;
                        r_o_last  <= last_el;
                        r_addr    <= addr_inc;
                        r_cnt     <= r_cnt + 1'b1;
                        r_state   <= last_el ? S_IDLE : S_OUT_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_o_valid;
    assign o_norm_value    = r_o_norm;
    assign o_frame_number  = r_o_fn;
    assign o_last_of_frame = r_o_last;

    `AFMRN_ASSERT_NEXT(a_div_starts, r_state == S_DIV, div_sts.busy)
    `AFMRN_ASSERT_NOW(a_div_done_waited, div_sts.done, r_state == S_DIV_WAIT)
    `AFMRN_ASSERT_NOW(a_root_normalized, r_state == S_OUT_RD, r_res[ROOT_W-1])
    `AFMRN_ASSERT_NOW(a_fill_bounded, 1'b1, r_fill <= FW'(MAX_FRAME))

endmodule
